// ----- hw/rtl/acp_pkg.sv -----
// ----------------------------------------------------------------------------
// acp_pkg: shared types, codes and AES helper functions
// Holds the types and codes used by the front, queue and back of the CBC
// engine, and the S-box tables, round functions and key schedule steps of the back.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int BlockBytes = 16;
  localparam int BlockBits  = 8 * BlockBytes;
  localparam int QueueDepth = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IV_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IV_LOW    = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_BAD_PAD = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENC,
    KIND_DEC,
    KIND_DEC_PART
  } kind_e;

  typedef struct packed {
    logic [BlockBits-1:0] data;
    kind_e                kind;
    logic                 last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for round key n, n from 1 to 10.
  function automatic logic [7:0] rcon(input logic [3:0] n);
    case (n)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    sub_rot = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    key_fwd = {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3, rc);
    key_inv = {p0, p1, p2, p3};
  endfunction

  // Byte i of a block sits at bits 127-8i down to 120-8i.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = SBOX[s[127-8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) -: 8]];
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) -: 8] = INV_SBOX[s[127-8*i -: 8]];
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    mix = t;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    mul9 = xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    mul11 = xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    mul13 = xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    mul14 = xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[119-32*c -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[111-32*c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[103-32*c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    inv_mix = t;
  endfunction

endpackage

// ----- hw/rtl/aes128_cbc_pkcs7_engine.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_pkcs7_engine: AES-128 CBC engine with PKCS#7 padding
// Encrypts or decrypts a message of 128-bit blocks in CBC mode.
// ----------------------------------------------------------------------------
// Flow: with the core free, an AES block is loaded, runs ten rounds and then
// waits for the result register; a partial decrypt block goes straight there.
// The single round unit works on one AES block at a time (one load step and
// ten rounds); a full last encrypt block becomes two AES blocks, itself and a pad.
// Reset: asynchronous, active low; after reset, and again after every key write,
// the decrypt key schedule runs to the final round key before a block is started.
// ----------------------------------------------------------------------------
module aes128_cbc_pkcs7_engine #(
  parameter int QueueDepth = acp_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [acp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [63:0]                    data_high_i,
  input  logic [63:0]                    data_low_i,
  input  logic [4:0]                     byte_count_i,
  input  logic                           is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [63:0]                    result_high_o,
  output logic [63:0]                    result_low_o,
  output logic [4:0]                     result_bytes_o,
  output logic                           result_last_o,
  output logic [1:0]                     status_o
);

  // Configuration registers. The key and direction are used directly; the IV
  // is only sampled when a message starts.
  logic        dir_q;
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        key_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        acp_pkg::CFG_DIRECTION: dir_q    <= cfg_wdata_i[0];
        acp_pkg::CFG_KEY_HIGH:  key_hi_q <= cfg_wdata_i;
        acp_pkg::CFG_KEY_LOW:   key_lo_q <= cfg_wdata_i;
        acp_pkg::CFG_IV_HIGH:   iv_hi_q  <= cfg_wdata_i;
        acp_pkg::CFG_IV_LOW:    iv_lo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A key write makes the back end rebuild its final round key.
  assign key_wr = cfg_we_i &&
                  (cfg_index_i == acp_pkg::CFG_KEY_HIGH || cfg_index_i == acp_pkg::CFG_KEY_LOW);

  acp_pkg::job_t push_job, pop_job;
  logic          push, q_ready, q_valid, pop;

  // The front classifies each item and splits a full last encrypt block into
  // the block itself and a whole pad block.
  acp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_high_i  (data_high_i),
    .data_low_i   (data_low_i),
    .byte_count_i (byte_count_i),
    .is_last_i    (is_last_i),
    .push_o       (push),
    .job_o        (push_job),
    .q_ready_i    (q_ready)
  );

  // The queue lets the front keep taking items while the core is busy.
  acp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .job_o      (pop_job),
    .pop_i      (pop)
  );

  // The back runs the rounds, keeps the chaining value and holds the result
  // in its own register, so a waiting result does not block the next job.
  acp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          ({key_hi_q, key_lo_q}),
    .iv_i           ({iv_hi_q, iv_lo_q}),
    .key_wr_i       (key_wr),
    .job_valid_i    (q_valid),
    .job_i          (pop_job),
    .job_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_high_o  (result_high_o),
    .result_low_o   (result_low_o),
    .result_bytes_o (result_bytes_o),
    .result_last_o  (result_last_o),
    .status_o       (status_o)
  );

endmodule

// ----- hw/rtl/acp_front.sv -----
// ----------------------------------------------------------------------------
// acp_front: input acceptance and classification
// Turns each input item into one or two jobs for the cipher back end,
// applying the encrypt padding and marking partial decrypt blocks.
// ----------------------------------------------------------------------------
module acp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              dir_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [63:0]                       data_high_i,
  input  logic [63:0]                       data_low_i,
  input  logic [4:0]                        byte_count_i,
  input  logic                              is_last_i,
  output logic                              push_o,
  output acp_pkg::job_t                     job_o,
  input  logic                              q_ready_i
);

  logic                          split_q;
  logic [4:0]                    cnt;
  logic [7:0]                    pad;
  logic [acp_pkg::BlockBits-1:0] din;
  logic [acp_pkg::BlockBits-1:0] padded;
  logic                          accept;

  assign din    = {data_high_i, data_low_i};
  assign cnt    = (byte_count_i > 5'(acp_pkg::BlockBytes)) ? 5'(acp_pkg::BlockBytes)
                                                           : byte_count_i;
  assign pad    = 8'(acp_pkg::BlockBytes) - {3'b000, cnt};
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < acp_pkg::BlockBytes; i++) begin
      padded[127-8*i -: 8] = (5'(i) < cnt) ? din[127-8*i -: 8] : pad;
    end
  end

  assign in_ready_o = !split_q && q_ready_i;
  assign push_o     = split_q ? q_ready_i : (in_valid_i && q_ready_i);

  always_comb begin
    job_o.data = din;
    job_o.last = is_last_i;
    job_o.kind = acp_pkg::KIND_ENC;
    if (split_q) begin
      // Whole pad block that follows a full last block.
      job_o.data = {acp_pkg::BlockBytes{8'(acp_pkg::BlockBytes)}};
      job_o.last = 1'b1;
    end else if (dir_i == acp_pkg::DIR_ENCRYPT) begin
      if (is_last_i && cnt != 5'(acp_pkg::BlockBytes)) begin
        job_o.data = padded;
      end else if (is_last_i) begin
        job_o.last = 1'b0;
      end
    end else if (cnt != 5'(acp_pkg::BlockBytes)) begin
      job_o.kind = acp_pkg::KIND_DEC_PART;
    end else begin
      job_o.kind = acp_pkg::KIND_DEC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b0;
    end else if (split_q) begin
      split_q <= !q_ready_i;
    end else if (accept && dir_i == acp_pkg::DIR_ENCRYPT && is_last_i &&
                 cnt == 5'(acp_pkg::BlockBytes)) begin
      split_q <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/acp_queue.sv -----
// ----------------------------------------------------------------------------
// acp_queue: job queue between front and back
// A small first-in first-out store of jobs so each side can stall alone.
// ----------------------------------------------------------------------------
module acp_queue #(
  parameter int Depth = acp_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acp_pkg::job_t push_job_i,
  output logic          ready_o,
  output logic          valid_o,
  output acp_pkg::job_t job_o,
  input  logic          pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  acp_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/acp_back.sv -----
// ----------------------------------------------------------------------------
// acp_back: iterative AES-128 core with CBC chaining
// One round per cycle, the last one held while the result register is full, with
// on-the-fly round keys, padding check on decrypt and a registered result stage.
// ----------------------------------------------------------------------------
module acp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [127:0]                      key_i,
  input  logic [127:0]                      iv_i,
  input  logic                              key_wr_i,
  input  logic                              job_valid_i,
  input  acp_pkg::job_t                     job_i,
  output logic                              job_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [63:0]                       result_high_o,
  output logic [63:0]                       result_low_o,
  output logic [4:0]                        result_bytes_o,
  output logic                              result_last_o,
  output logic [1:0]                        status_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [3:0] LastRound = 4'd10;

  logic                 state_q;
  logic [3:0]           rnd_q;
  logic [127:0]         st_q, k_q, dk_q, kx_q, chain_q, cin_q;
  logic                 start_q, last_q;
  acp_pkg::kind_e       kind_q;
  logic                 kpend_q, kbusy_q;
  logic [3:0]           kcnt_q;
  logic [127:0]         kx_next;

  logic                 ov_q, olast_q;
  logic [127:0]         odata_q;
  logic [4:0]           obytes_q;
  logic [1:0]           ostat_q;

  logic [127:0] chain_sel, enc_rk, dec_rk, enc_nx, dec_nx, dec_pt;
  logic [7:0]   p;
  logic         pad_ok;
  logic         out_free, key_ok, take, finish;

  assign chain_sel = start_q ? iv_i : chain_q;
  assign enc_rk    = acp_pkg::key_fwd(k_q, acp_pkg::rcon(rnd_q));
  assign dec_rk    = acp_pkg::key_inv(k_q, acp_pkg::rcon(4'd11 - rnd_q));
  assign kx_next   = acp_pkg::key_fwd(kx_q, acp_pkg::rcon(kcnt_q));

  always_comb begin
    enc_nx = acp_pkg::sub_shift(st_q);
    if (rnd_q != LastRound) begin
      enc_nx = acp_pkg::mix(enc_nx);
    end
    enc_nx = enc_nx ^ enc_rk;
    dec_nx = acp_pkg::inv_shift_sub(st_q) ^ dec_rk;
    if (rnd_q != LastRound) begin
      dec_nx = acp_pkg::inv_mix(dec_nx);
    end
  end

  assign dec_pt = dec_nx ^ chain_sel;
  assign p      = dec_pt[7:0];

  // Good padding: pad value 1 to 16 and the last p bytes all equal to it.
  always_comb begin
    pad_ok = (p >= 8'd1) && (p <= 8'(acp_pkg::BlockBytes));
    for (int i = 0; i < acp_pkg::BlockBytes; i++) begin
      if ((8'(i) < p) && (dec_pt[8*i +: 8] != p)) begin
        pad_ok = 1'b0;
      end
    end
  end

  assign out_free  = !ov_q || out_ready_i;
  assign key_ok    = !kpend_q && !kbusy_q;
  assign take      = (state_q == ST_IDLE) && job_valid_i && key_ok &&
                     (job_i.kind != acp_pkg::KIND_DEC_PART || out_free);
  assign finish    = (state_q == ST_RUN) && (rnd_q == LastRound) && out_free;
  assign job_pop_o = take;

  // Final round key for decryption, rebuilt after every key write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpend_q <= 1'b1;
      kbusy_q <= 1'b0;
      kcnt_q  <= '0;
    end else begin
      kpend_q <= key_wr_i;
      if (kpend_q) begin
        kbusy_q <= 1'b1;
        kcnt_q  <= 4'd1;
      end else if (kbusy_q) begin
        kcnt_q <= kcnt_q + 4'd1;
        if (kcnt_q == LastRound) begin
          kbusy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (kpend_q) begin
      kx_q <= key_i;
    end else if (kbusy_q) begin
      kx_q <= kx_next;
      if (kcnt_q == LastRound) begin
        dk_q <= kx_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      start_q <= 1'b1;
      chain_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (take) begin
        if (job_i.kind == acp_pkg::KIND_DEC_PART) begin
          ov_q <= 1'b1;
          if (job_i.last) begin
            start_q <= 1'b1;
          end
        end else begin
          state_q <= ST_RUN;
          rnd_q   <= 4'd1;
        end
      end else if (state_q == ST_RUN && rnd_q != LastRound) begin
        rnd_q <= rnd_q + 4'd1;
      end else if (finish) begin
        state_q <= ST_IDLE;
        ov_q    <= 1'b1;
        start_q <= last_q;
        chain_q <= (kind_q == acp_pkg::KIND_ENC) ? enc_nx : cin_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (job_i.kind == acp_pkg::KIND_DEC_PART) begin
        odata_q  <= '0;
        obytes_q <= '0;
        olast_q  <= job_i.last;
        ostat_q  <= acp_pkg::STATUS_PARTIAL;
      end else if (job_i.kind == acp_pkg::KIND_ENC) begin
        st_q <= job_i.data ^ chain_sel ^ key_i;
        k_q  <= key_i;
      end else begin
        st_q <= job_i.data ^ dk_q;
        k_q  <= dk_q;
      end
      cin_q  <= job_i.data;
      kind_q <= job_i.kind;
      last_q <= job_i.last;
    end else if (state_q == ST_RUN && rnd_q != LastRound) begin
      st_q <= (kind_q == acp_pkg::KIND_ENC) ? enc_nx : dec_nx;
      k_q  <= (kind_q == acp_pkg::KIND_ENC) ? enc_rk : dec_rk;
    end else if (finish) begin
      olast_q <= last_q;
      if (kind_q == acp_pkg::KIND_ENC) begin
        odata_q  <= enc_nx;
        obytes_q <= 5'(acp_pkg::BlockBytes);
        ostat_q  <= acp_pkg::STATUS_OK;
      end else begin
        odata_q  <= dec_pt;
        obytes_q <= 5'(acp_pkg::BlockBytes);
        ostat_q  <= acp_pkg::STATUS_OK;
        if (last_q && pad_ok) begin
          obytes_q <= 5'(acp_pkg::BlockBytes) - p[4:0];
        end else if (last_q) begin
          ostat_q <= acp_pkg::STATUS_BAD_PAD;
        end
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign result_high_o  = odata_q[127:64];
  assign result_low_o   = odata_q[63:0];
  assign result_bytes_o = obytes_q;
  assign result_last_o  = olast_q;
  assign status_o       = ostat_q;

endmodule

// ----- hw/rtl/acp_checker.sv -----
// ----------------------------------------------------------------------------
// acp_checker: port-level checks for the CBC engine
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
module acp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] result_bytes_o,
  input logic [1:0] status_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_bytes_o <= 5'(acp_pkg::BlockBytes))
    else $error("result byte count above block size");

  a_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == acp_pkg::STATUS_PARTIAL |-> result_bytes_o == 5'd0)
    else $error("partial block with non-zero byte count");

  a_pad_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == acp_pkg::STATUS_BAD_PAD
      |-> result_bytes_o == 5'(acp_pkg::BlockBytes))
    else $error("bad padding without full byte count");

endmodule

bind aes128_cbc_pkcs7_engine acp_checker u_checker (.*);
